FILE: hw/rtl/tdvl_pkg.sv
package tdvl_pkg;

  localparam int ATAN_LEN      = 20;
  localparam int CORDIC_STEPS  = 14;
  localparam int CW            = 27;
  localparam int ZW            = 27;

  localparam logic [15:0]        YAW_TOLERANCE = 16'd410;
  localparam logic signed [15:0] MIN_X_Q12     = 16'sd205;
  localparam logic signed [16:0] PI_Q13        = 17'sd25736;
  localparam logic signed [16:0] TWO_PI_Q13    = 17'sd51472;

  localparam logic [23:0] ATAN_Q24 [ATAN_LEN] = '{
    24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331, 24'd1047214,
    24'd524117,   24'd262123,  24'd131069,  24'd65536,   24'd32768,
    24'd16384,    24'd8192,    24'd4096,    24'd2048,    24'd1024,
    24'd512,      24'd256,     24'd128,     24'd64,      24'd32
  };

  localparam logic [3:0] REG_DESIRED_DISTANCE   = 4'd0;
  localparam logic [3:0] REG_MAX_LINEAR         = 4'd1;
  localparam logic [3:0] REG_MAX_ANGULAR        = 4'd2;
  localparam logic [3:0] REG_DIST_KP            = 4'd3;
  localparam logic [3:0] REG_HEAD_KP            = 4'd4;
  localparam logic [3:0] REG_LAT_KP             = 4'd5;
  localparam logic [3:0] REG_DISTANCE_TOLERANCE = 4'd6;
  localparam logic [3:0] REG_LATERAL_TOLERANCE  = 4'd7;

endpackage

FILE: hw/rtl/tag_docking_velocity_law_core.sv
// Docking velocity law: turns one tag pose (rel_x, rel_y in Q4.12 m, tag_yaw in Q3.13 rad)
// into a clamped linear and angular command plus the three errors and an arrival flag.
// The block is a pipeline of min(CORDIC_STEPS, 20) + 4 stages: one for the error terms,
// one per CORDIC vectoring step for atan2(rel_y, max(rel_x, 0.05 m)), one for rounding the
// angle and the distance product, one for the heading and lateral products and the linear
// clamp, and one for the angular sum and clamp. A pose is taken every cycle while in_stall is
// low, and its transaction moves through the stages in order; stages that hold no item close
// up under an output stall, so input is taken until every stage is full. The user must write
// registers via cfg_we/cfg_index/cfg_wdata only while no pose is in flight; the block
// does not enforce this. Writes to an index above 7 are dropped.
module tag_docking_velocity_law_core #(
  parameter int CORDIC_STEPS = tdvl_pkg::CORDIC_STEPS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_rel_x,
  input  logic signed [15:0] in_rel_y,
  input  logic signed [15:0] in_tag_yaw,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [14:0]        out_linear_cmd,
  output logic signed [15:0] out_angular_cmd,
  output logic signed [16:0] out_distance_err,
  output logic signed [15:0] out_lateral_err,
  output logic signed [15:0] out_heading_err,
  output logic               out_within_tolerance
);
  import tdvl_pkg::*;

  localparam int NSTEP = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam int ST_T  = NSTEP + 1;
  localparam int ST_M  = NSTEP + 2;
  localparam int ST_O  = NSTEP + 3;
  localparam int L     = NSTEP + 4;

  logic [14:0] desired_distance_r, max_linear_r, max_angular_r;
  logic [15:0] dist_kp_r, head_kp_r, lat_kp_r;
  logic [14:0] distance_tolerance_r, lateral_tolerance_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desired_distance_r   <= 15'd2048;
      max_linear_r         <= 15'd1024;
      max_angular_r        <= 15'd4096;
      dist_kp_r            <= 16'd2048;
      head_kp_r            <= 16'd4096;
      lat_kp_r             <= 16'd4096;
      distance_tolerance_r <= 15'd82;
      lateral_tolerance_r  <= 15'd82;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DESIRED_DISTANCE:   desired_distance_r   <= cfg_wdata[14:0];
        REG_MAX_LINEAR:         max_linear_r         <= cfg_wdata[14:0];
        REG_MAX_ANGULAR:        max_angular_r        <= cfg_wdata[14:0];
        REG_DIST_KP:            dist_kp_r            <= cfg_wdata;
        REG_HEAD_KP:            head_kp_r            <= cfg_wdata;
        REG_LAT_KP:             lat_kp_r             <= cfg_wdata;
        REG_DISTANCE_TOLERANCE: distance_tolerance_r <= cfg_wdata[14:0];
        REG_LATERAL_TOLERANCE:  lateral_tolerance_r  <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // stage enables: a stage loads when empty or when its content moves on
  logic [L-1:0] v_r;
  logic [L-1:0] en;

  always_comb begin
    en[L-1] = !v_r[L-1] || !out_stall;
    for (int k = L - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < L; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // stage 0: error terms and CORDIC seed
  logic signed [15:0] xc;
  logic signed [16:0] derr_nxt;
  logic signed [16:0] hraw;
  logic signed [16:0] hwrap;

  always_comb begin
    xc       = (in_rel_x > MIN_X_Q12) ? in_rel_x : MIN_X_Q12;
    derr_nxt = $signed({in_rel_x[15], in_rel_x}) - $signed({2'b00, desired_distance_r});
    hraw     = $signed({in_tag_yaw[15], in_tag_yaw}) - PI_Q13;
    hwrap    = (hraw < -PI_Q13) ? hraw + TWO_PI_Q13 : hraw;
  end

  logic signed [16:0] derr_r [L];
  logic signed [15:0] herr_r [L];
  logic signed [15:0] lat_r  [L];
  logic signed [CW-1:0] cx_r [NSTEP+1];
  logic signed [CW-1:0] cy_r [NSTEP+1];
  logic signed [ZW-1:0] cz_r [NSTEP+1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      derr_r[0] <= derr_nxt;
      herr_r[0] <= hwrap[15:0];
      lat_r[0]  <= in_rel_y;
      cx_r[0]   <= $signed({{(CW-24){xc[15]}}, xc, 8'b0});
      cy_r[0]   <= $signed({{(CW-24){in_rel_y[15]}}, in_rel_y, 8'b0});
      cz_r[0]   <= '0;
    end
  end

  genvar g;
  generate
    for (g = 1; g < L; g++) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[g]) begin
          derr_r[g] <= derr_r[g-1];
          herr_r[g] <= herr_r[g-1];
          lat_r[g]  <= lat_r[g-1];
        end
      end
    end

    for (g = 1; g <= NSTEP; g++) begin : g_cordic
      always_ff @(posedge clk) begin
        if (en[g]) begin
          if (!cy_r[g-1][CW-1]) begin
            cx_r[g] <= cx_r[g-1] + (cy_r[g-1] >>> (g - 1));
            cy_r[g] <= cy_r[g-1] - (cx_r[g-1] >>> (g - 1));
            cz_r[g] <= cz_r[g-1] + $signed(ZW'(ATAN_Q24[g-1]));
          end else begin
            cx_r[g] <= cx_r[g-1] - (cy_r[g-1] >>> (g - 1));
            cy_r[g] <= cy_r[g-1] + (cx_r[g-1] >>> (g - 1));
            cz_r[g] <= cz_r[g-1] - $signed(ZW'(ATAN_Q24[g-1]));
          end
        end
      end
    end
  endgenerate

  // stage T: round angle, arrival flag, distance product
  logic signed [ZW-1:0] zr;
  logic [16:0]          dabs;
  logic [16:0]          yabs;
  logic [15:0]          habs;
  logic signed [16:0]   d_t;
  logic signed [15:0]   y_t;
  logic signed [15:0]   h_t;

  always_comb begin
    d_t  = derr_r[NSTEP];
    y_t  = lat_r[NSTEP];
    h_t  = herr_r[NSTEP];
    zr   = cz_r[NSTEP] + $signed(ZW'(1024));
    dabs = d_t[16] ? 17'(-d_t) : 17'(d_t);
    yabs = y_t[15] ? 17'(-$signed({y_t[15], y_t})) : {1'b0, y_t};
    habs = h_t[15] ? 16'(-h_t) : 16'(h_t);
  end

  logic signed [15:0] theta_r;
  logic               ok_t_r, ok_m_r, ok_o_r;
  logic signed [33:0] dprod_r;

  always_ff @(posedge clk) begin
    if (en[ST_T]) begin
      theta_r <= zr[ZW-1:11];
      ok_t_r  <= (dabs <= {2'b00, distance_tolerance_r}) &&
                 (yabs <= {2'b00, lateral_tolerance_r}) &&
                 (habs <= YAW_TOLERANCE);
      dprod_r <= d_t * $signed({1'b0, dist_kp_r});
    end
  end

  // stage M: heading and lateral products, linear clamp
  logic signed [33:0] lsum;
  logic signed [21:0] lsh;
  logic [14:0]        lin_nxt;

  always_comb begin
    lsum = dprod_r + 34'sd2048;
    lsh  = lsum[33:12];
    if (lsh[21]) begin
      lin_nxt = '0;
    end else if ($unsigned(lsh) > {7'b0, max_linear_r}) begin
      lin_nxt = max_linear_r;
    end else begin
      lin_nxt = lsh[14:0];
    end
  end

  logic signed [32:0] hprod_r;
  logic signed [32:0] lprod_r;
  logic [14:0]        lin_m_r, lin_o_r;

  always_ff @(posedge clk) begin
    if (en[ST_M]) begin
      hprod_r <= herr_r[ST_T] * $signed({1'b0, head_kp_r});
      lprod_r <= theta_r * $signed({1'b0, lat_kp_r});
      lin_m_r <= lin_nxt;
      ok_m_r  <= ok_t_r;
    end
  end

  // stage O: angular sum, round, clamp
  logic signed [33:0] asum;
  logic signed [21:0] ash;
  logic signed [21:0] amax;
  logic signed [15:0] ang_nxt;

  always_comb begin
    asum = $signed({hprod_r[32], hprod_r}) + $signed({lprod_r[32], lprod_r}) + 34'sd2048;
    ash  = asum[33:12];
    amax = $signed({7'b0, max_angular_r});
    if (ash > amax) begin
      ang_nxt = amax[15:0];
    end else if (ash < -amax) begin
      ang_nxt = 16'(-amax);
    end else begin
      ang_nxt = ash[15:0];
    end
  end

  logic signed [15:0] ang_o_r;

  always_ff @(posedge clk) begin
    if (en[ST_O]) begin
      ang_o_r <= ang_nxt;
      lin_o_r <= lin_m_r;
      ok_o_r  <= ok_m_r;
    end
  end

  assign out_valid            = v_r[L-1];
  assign out_linear_cmd       = lin_o_r;
  assign out_angular_cmd      = ang_o_r;
  assign out_distance_err     = derr_r[L-1];
  assign out_lateral_err      = lat_r[L-1];
  assign out_heading_err      = herr_r[L-1];
  assign out_within_tolerance = ok_o_r;

endmodule
